// ===== hw/rtl/cfb_pkg.sv =====
// ---------------------------------------------------------------------------
// cfb_pkg: shared types and constants for the command frame builder
// Beat structs, queue entry format, register map and frame constants.
// ---------------------------------------------------------------------------
package cfb_pkg;

  // Frame constants
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] LEN_EXTRA = 16'h000D;

  // Configuration port
  localparam int          ADDR_W = 4;
  localparam int          DATA_W = 32;
  localparam logic [1:0]  REG_HEADER_HIGH    = 2'd0;
  localparam logic [1:0]  REG_HEADER_LOW     = 2'd1;
  localparam logic [1:0]  REG_DEVICE_ADDRESS = 2'd2;
  localparam logic [1:0]  REG_UNIT_ID        = 2'd3;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Back-end byte step positions
  localparam int          STEP_W          = 4;
  localparam logic [3:0]  STEP_FIRST      = 4'd0;
  localparam logic [3:0]  STEP_HDR_LAST   = 4'd10;
  localparam logic [3:0]  STEP_HDR_CRC_HI = 4'd11;
  localparam logic [3:0]  STEP_DAT_CRC_HI = 4'd1;

  // Input beat
  typedef struct packed {
    logic        req_type;
    logic [31:0] command;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       stray_error;
  } out_item_t;

  // Request codes on req_type
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Register file contents seen by the back end
  typedef struct packed {
    logic [7:0]  header_high;
    logic [7:0]  header_low;
    logic [7:0]  device_address;
    logic [15:0] unit_id;
  } cfg_regs_t;

  // Classified operation
  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_STRAY
  } op_kind_t;

  // Queue entry from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic        last;       // frame closes after this op (CRC follows)
    logic [31:0] command;
    logic [15:0] total_len;
    logic [7:0]  data_byte;
  } q_entry_t;

endpackage

// ===== hw/rtl/command_frame_builder_crc16_top.sv =====
// ---------------------------------------------------------------------------
// command_frame_builder_crc16_top: serial command frame builder with CRC-16
// Front classifier, command queue, byte sequencer and APB register file.
// ---------------------------------------------------------------------------
// Each output beat is one frame byte. A payload beat yields one byte from the
// back-end sequencer (three when it is the frame's last byte, adding the two
// CRC bytes); a start beat yields 11 header bytes, 13 when its payload length
// is zero. The sequencer emits one byte per cycle while not stalled by
// out_ready or an empty queue, and sets the rate; the front accepts up to
// QUEUE_DEPTH items ahead of it, so a header burst stalls in_ready only once
// the queue fills. CRC-16/CCITT-FALSE covers every frame byte before the
// trailer. Configuration must be written only while idle (not enforced).
module command_frame_builder_crc16_top #(
  parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cfb_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cfb_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfb_pkg::ADDR_W-1:0] paddr,
  input  logic [cfb_pkg::DATA_W-1:0] pwdata,
  output logic [cfb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import cfb_pkg::*;

  cfg_regs_t cfg;
  q_entry_t  push_entry, head;
  logic      push, pop, q_full, q_empty;

  cfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  cfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/cfb_regs.sv =====
// ---------------------------------------------------------------------------
// cfb_regs: APB-style configuration registers
// Holds header bytes, device address and unit id; read back on prdata.
// ---------------------------------------------------------------------------
module cfb_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfb_pkg::ADDR_W-1:0] paddr,
  input  logic [cfb_pkg::DATA_W-1:0] pwdata,
  output logic [cfb_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output cfb_pkg::cfg_regs_t        cfg
);
  import cfb_pkg::*;

  cfg_regs_t   regs_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEADER_HIGH:    regs_r.header_high    <= pwdata[7:0];
        REG_HEADER_LOW:     regs_r.header_low     <= pwdata[7:0];
        REG_DEVICE_ADDRESS: regs_r.device_address <= pwdata[7:0];
        REG_UNIT_ID:        regs_r.unit_id        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_HEADER_HIGH:    prdata = {24'd0, regs_r.header_high};
      REG_HEADER_LOW:     prdata = {24'd0, regs_r.header_low};
      REG_DEVICE_ADDRESS: prdata = {24'd0, regs_r.device_address};
      REG_UNIT_ID:        prdata = {16'd0, regs_r.unit_id};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cfb_front.sv =====
// ---------------------------------------------------------------------------
// cfb_front: input classifier
// Tracks the open frame and turns each input beat into a queue entry.
// ---------------------------------------------------------------------------
module cfb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfb_pkg::in_item_t   in_data,
  output logic                push,
  output cfb_pkg::q_entry_t   push_entry,
  input  logic                q_full
);
  import cfb_pkg::*;

  logic        open_r,   open_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  // classify the beat and work out the frame tracking update
  always_comb begin
    open_nxt              = open_r;
    remain_nxt            = remain_r;
    push_entry.command    = in_data.command;
    push_entry.total_len  = in_data.payload_len + LEN_EXTRA;
    push_entry.data_byte  = in_data.data_byte;
    push_entry.kind       = OP_STRAY;
    push_entry.last       = 1'b0;
    if (in_data.req_type == REQ_START) begin
      push_entry.kind = OP_START;
      push_entry.last = (in_data.payload_len == 16'd0);
      open_nxt        = (in_data.payload_len != 16'd0);
      remain_nxt      = in_data.payload_len;
    end else if (open_r) begin
      push_entry.kind = OP_DATA;
      push_entry.last = (remain_r == 16'd1);
      open_nxt        = (remain_r != 16'd1);
      remain_nxt      = remain_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      remain_r <= '0;
    end else if (accept) begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// ===== hw/rtl/cfb_queue.sv =====
// ---------------------------------------------------------------------------
// cfb_queue: small command queue between front and back
// Register-based FIFO; head entry is visible to the back end every cycle.
// ---------------------------------------------------------------------------
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cfb_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output cfb_pkg::q_entry_t  head,
  output logic               full,
  output logic               empty
);
  import cfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cfb_back.sv =====
// ---------------------------------------------------------------------------
// cfb_back: byte sequencer and CRC engine
// Expands queue entries into output beats and appends the CRC-16 trailer.
// ---------------------------------------------------------------------------
module cfb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cfb_pkg::cfg_regs_t  cfg,
  input  cfb_pkg::q_entry_t   head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cfb_pkg::out_item_t  out_data
);
  import cfb_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [15:0]       crc_r, crc_seed, crc_nxt;
  logic              out_valid_r;
  out_item_t         out_r, beat;
  logic              advance, done, crc_en;

  // CRC-16/CCITT-FALSE, one byte msb-first
  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  // header byte at a given step
  function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] s,
                                          input cfg_regs_t c,
                                          input q_entry_t e);
    logic [7:0] b;
    case (s)
      4'd0:    b = c.header_high;
      4'd1:    b = c.header_low;
      4'd2:    b = e.total_len[15:8];
      4'd3:    b = e.total_len[7:0];
      4'd4:    b = c.device_address;
      4'd5:    b = c.unit_id[15:8];
      4'd6:    b = c.unit_id[7:0];
      4'd7:    b = e.command[31:24];
      4'd8:    b = e.command[23:16];
      4'd9:    b = e.command[15:8];
      default: b = e.command[7:0];
    endcase
    return b;
  endfunction

  assign advance   = !q_empty && (!out_valid_r || out_ready);
  assign pop       = advance && done;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // select the beat for the head entry at the current step
  always_comb begin
    beat   = '0;
    done   = 1'b1;
    crc_en = 1'b0;
    case (head.kind)
      OP_START: begin
        if (step_r <= STEP_HDR_LAST) begin
          beat.out_byte = hdr_byte(step_r, cfg, head);
          crc_en        = 1'b1;
          done          = (step_r == STEP_HDR_LAST) && !head.last;
        end else if (step_r == STEP_HDR_CRC_HI) begin
          beat.out_byte = crc_r[15:8];
          done          = 1'b0;
        end else begin
          beat.out_byte  = crc_r[7:0];
          beat.frame_end = 1'b1;
        end
      end
      OP_DATA: begin
        if (step_r == STEP_FIRST) begin
          beat.out_byte = head.data_byte;
          crc_en        = 1'b1;
          done          = !head.last;
        end else if (step_r == STEP_DAT_CRC_HI) begin
          beat.out_byte = crc_r[15:8];
          done          = 1'b0;
        end else begin
          beat.out_byte  = crc_r[7:0];
          beat.frame_end = 1'b1;
        end
      end
      OP_STRAY: begin
        beat.stray_error = 1'b1;
      end
      default: ;
    endcase
  end

  // new frame restarts the CRC
  assign crc_seed = (head.kind == OP_START && step_r == STEP_FIRST) ? CRC_INIT : crc_r;
  assign crc_nxt  = crc_en ? crc_upd(crc_seed, beat.out_byte) : crc_r;

  // payload register for the output beat
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= beat;
    end
  end

  // control: step counter, CRC, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      crc_r       <= crc_nxt;
      step_r      <= done ? '0 : step_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/cfb_checker.sv =====
// ---------------------------------------------------------------------------
// cfb_checker: port-level assertions for the frame builder
// Watches the top-level ports; attached by the bind at the end of the file.
// ---------------------------------------------------------------------------
module cfb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input cfb_pkg::out_item_t         out_data,
  input logic [cfb_pkg::DATA_W-1:0] prdata,
  input logic                       pready
);
  import cfb_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a stray beat carries nothing else
  a_stray_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stray_error |-> !out_data.frame_end && out_data.out_byte == 8'd0)
    else $error("stray error beat with data or frame end");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // registers are at most 16 bits wide and the port never waits
  a_apb_read: assert property (@(posedge clk) disable iff (!rst_n)
    pready && prdata[31:16] == 16'd0)
    else $error("bad configuration read data or wait state");

endmodule

bind command_frame_builder_crc16_top cfb_checker u_cfb_checker (.*);
